// ===== rtl/core/gnd_pkg.sv =====
// Shared types and constants for the greedy note dispenser core.
// Used by gnd_cell and greedy_note_dispenser_core; no dependencies.
package gnd_pkg;

   localparam int SLOTS  = 4;
   localparam int NREGS  = 4;
   localparam int NOTE_W = 8;
   localparam int AMT_W  = 16;
   localparam int SLOT_W = 2;
   localparam int BIT_W  = 3;
   localparam int ACC_W  = AMT_W + NOTE_W;
   localparam int IDX_W  = 2;

   localparam logic [AMT_W-1:0] DENOM_RESET [NREGS] = '{16'd100, 16'd50, 16'd20, 16'd1};

   typedef enum logic {
      FUNC_DISPENSE = 1'b0,
      FUNC_REFILL   = 1'b1
   } func_type;

   typedef struct packed {
      func_type             func;
      logic [AMT_W-1:0]     amount;
      logic [SLOT_W-1:0]    slot;
      logic [NOTE_W-1:0]    refill_count;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    out_slot;
      logic [NOTE_W-1:0]    notes_used;
      logic [AMT_W-1:0]     remaining;
      logic                 success;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      rsp_type              data;
   } cell_rsp_type;

   typedef struct packed {
      logic                 go;
      logic [AMT_W-1:0]     remaining;
   } link_type;

   typedef struct packed {
      logic                 en;
      logic [NOTE_W-1:0]    count;
   } refill_type;

endpackage

// ===== rtl/core/gnd_cell.sv =====
// One note slot of the dispenser chain: holds the slot's stock and finds the
// note count bit by bit. Depends on gnd_pkg.
module gnd_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gnd_pkg::SLOT_W-1:0] cell_index,
   input  logic [gnd_pkg::AMT_W-1:0]  denom_value,
   input  gnd_pkg::refill_type        refill,
   input  gnd_pkg::link_type          link_in,
   output gnd_pkg::link_type          link_out,
   output gnd_pkg::cell_rsp_type      rsp
);
   import gnd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_INDEX = SLOT_W'(SLOTS - 1);

   state_type          state_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic [NOTE_W-1:0]  stock_ff;
   logic [NOTE_W-1:0]  use_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [AMT_W-1:0]   amt_ff;
   link_type           link_ff;
   cell_rsp_type       rsp_ff;

   logic [ACC_W-1:0]   shifted_in;
   logic [ACC_W-1:0]   trial_in;
   logic [NOTE_W-1:0]  cand_in;
   logic               take_in;
   logic [NOTE_W-1:0]  use_in;
   logic [ACC_W-1:0]   acc_in;
   logic [AMT_W-1:0]   rem_in;
   logic               is_last_in;

   always_comb begin
      shifted_in = {{NOTE_W{1'b0}}, denom_value} << bit_ff;
      trial_in   = acc_ff + shifted_in;
      cand_in    = use_ff | (NOTE_W'(1) << bit_ff);
      take_in    = (cand_in <= stock_ff) && (trial_in <= {{NOTE_W{1'b0}}, amt_ff});
      use_in     = take_in ? cand_in : use_ff;
      acc_in     = take_in ? trial_in : acc_ff;
      rem_in     = amt_ff - acc_in[AMT_W-1:0];
      is_last_in = (cell_index == LAST_INDEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stock_ff       <= '0;
         link_ff.go     <= 1'b0;
         rsp_ff.valid   <= 1'b0;
      end else begin
         link_ff.go   <= 1'b0;
         rsp_ff.valid <= 1'b0;
         if (refill.en) begin
            stock_ff <= refill.count;
         end
         case (state_ff)
            ST_IDLE: begin
               if (link_in.go) begin
                  amt_ff   <= link_in.remaining;
                  use_ff   <= '0;
                  acc_ff   <= '0;
                  bit_ff   <= BIT_W'(NOTE_W - 1);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               use_ff <= use_in;
               acc_ff <= acc_in;
               bit_ff <= bit_ff - BIT_W'(1);
               if (bit_ff == '0) begin
                  stock_ff                <= stock_ff - use_in;
                  link_ff.go              <= ~is_last_in;
                  link_ff.remaining       <= rem_in;
                  rsp_ff.valid            <= 1'b1;
                  rsp_ff.data.out_slot    <= cell_index;
                  rsp_ff.data.notes_used  <= use_in;
                  rsp_ff.data.remaining   <= rem_in;
                  rsp_ff.data.success     <= is_last_in && (rem_in == '0);
                  rsp_ff.data.last        <= is_last_in;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign link_out = link_ff;
   assign rsp      = rsp_ff;

endmodule

// ===== rtl/core/greedy_note_dispenser_core.sv =====
// Top level of the greedy note dispenser: config registers, command intake
// and a chain of gnd_cell slots. Depends on gnd_pkg and gnd_cell.
//
// Usage:
//  - Commands: a beat on req_payload is taken at a clock edge with start high
//    and busy low. busy stays high until the last result beat of the command.
//  - Dispense (func 0) walks the slot chain from slot 0 to the last slot. Each
//    cell loads the amount it is handed, then resolves its note count one bit per
//    cycle and then hands the remaining amount to its neighbor. One result beat
//    per slot comes out, slot 0 first; the next command is taken only after the
//    last of them.
//  - Refill (func 1) sets one slot's stock; its single result beat appears
//    in the cycle after the command.
//  - Results: rsp_valid marks each beat for exactly one cycle; the receiver
//    cannot stall and must take every beat as it comes.
//  - Config: csr_wr_en writes csr_wdata into the note value register at
//    csr_index at once; write only while busy is low.
//  - Reset: synchronous, active high; all stock is zero, note values return
//    to 100, 50, 20 and 1, and no command is in flight.
module greedy_note_dispenser_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gnd_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   output gnd_pkg::rsp_type          rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [gnd_pkg::IDX_W-1:0] csr_index,
   input  logic [gnd_pkg::AMT_W-1:0] csr_wdata
);
   import gnd_pkg::*;

   localparam logic [SLOT_W:0] SLOT_LIMIT = SLOTS[SLOT_W:0];

   logic [AMT_W-1:0]  denom_ff [NREGS];
   logic              busy_ff;
   cell_rsp_type      refill_rsp_ff;

   logic              accept_in;
   logic              refill_ok_in;
   link_type          link [SLOTS+1];
   cell_rsp_type      cell_rsp [SLOTS];
   refill_type        refill [SLOTS];
   cell_rsp_type      merged_in;

   assign accept_in    = start && !busy_ff;
   assign refill_ok_in = ({1'b0, req_payload.slot} < SLOT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREGS; i++) begin
            denom_ff[i] <= DENOM_RESET[i];
         end
      end else if (csr_wr_en) begin
         denom_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff             <= 1'b0;
         refill_rsp_ff.valid <= 1'b0;
      end else begin
         refill_rsp_ff.valid <= 1'b0;
         if (accept_in) begin
            busy_ff <= 1'b1;
            if (req_payload.func == FUNC_REFILL) begin
               refill_rsp_ff.valid           <= 1'b1;
               refill_rsp_ff.data.out_slot   <= req_payload.slot;
               refill_rsp_ff.data.notes_used <= refill_ok_in ? req_payload.refill_count : '0;
               refill_rsp_ff.data.remaining  <= '0;
               refill_rsp_ff.data.success    <= refill_ok_in;
               refill_rsp_ff.data.last       <= 1'b1;
            end
         end else if (merged_in.valid && merged_in.data.last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign link[0].go        = accept_in && (req_payload.func == FUNC_DISPENSE);
   assign link[0].remaining = req_payload.amount;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      assign refill[k].en    = accept_in && (req_payload.func == FUNC_REFILL) &&
                               ({1'b0, req_payload.slot} == (SLOT_W+1)'(k));
      assign refill[k].count = req_payload.refill_count;

      gnd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (SLOT_W'(k)),
         .denom_value (denom_ff[k % NREGS]),
         .refill      (refill[k]),
         .link_in     (link[k]),
         .link_out    (link[k+1]),
         .rsp         (cell_rsp[k])
      );
   end

   always_comb begin
      merged_in = '0;
      if (refill_rsp_ff.valid) begin
         merged_in = refill_rsp_ff;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (cell_rsp[i].valid) begin
            merged_in = merged_in | cell_rsp[i];
         end
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = merged_in.valid;
   assign rsp_payload = merged_in.data;

   logic [SLOTS:0] beat_sources;
   always_comb begin
      beat_sources[SLOTS] = refill_rsp_ff.valid;
      for (int i = 0; i < SLOTS; i++) begin
         beat_sources[i] = cell_rsp[i].valid;
      end
   end

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      $onehot0(beat_sources))
      else $error("more than one result source active");

   a_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("result beat with no command in flight");

   a_refill_beat: assert property (@(posedge clock) disable iff (reset)
      (accept_in && req_payload.func == FUNC_REFILL) |=> (rsp_valid && rsp_payload.last))
      else $error("refill did not answer in one cycle");

   a_no_go_on_refill: assert property (@(posedge clock) disable iff (reset)
      refill_rsp_ff.valid |-> !link[1].go)
      else $error("chain advancing during refill");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for greedy_note_dispenser_core: directed and random dispense
// and refill commands under several note value settings, every result beat checked
// against an in-bench payout predictor. Depends on gnd_pkg and the core.
module tb_top;
   import gnd_pkg::*;

   localparam logic [IDX_W-1:0] REG_DENOM_0 = 2'd0;
   localparam logic [IDX_W-1:0] REG_DENOM_1 = 2'd1;
   localparam logic [IDX_W-1:0] REG_DENOM_2 = 2'd2;
   localparam logic [IDX_W-1:0] REG_DENOM_3 = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_TAIL  = 40;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_payload = '0;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_wr_en   = 1'b0;
   logic [IDX_W-1:0] csr_index   = '0;
   logic [AMT_W-1:0] csr_wdata   = '0;

   logic [AMT_W-1:0]  note_value  [NREGS];
   logic [NOTE_W-1:0] shelf_stock [SLOTS];
   rsp_type           payout_queue [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                burst_left  = 0;

   greedy_note_dispenser_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (payout_queue.size() == 0) begin
            $error("result beat with nothing expected: out_slot %0d", rsp_payload.out_slot);
            error_count++;
         end else begin
            want = payout_queue.pop_front();
            if (rsp_payload.out_slot !== want.out_slot) begin
               $error("out_slot: expected %0d, actual %0d", want.out_slot,
                      rsp_payload.out_slot);
               error_count++;
            end
            if (rsp_payload.notes_used !== want.notes_used) begin
               $error("notes_used: expected %0d, actual %0d", want.notes_used,
                      rsp_payload.notes_used);
               error_count++;
            end
            if (rsp_payload.remaining !== want.remaining) begin
               $error("remaining: expected %0d, actual %0d", want.remaining,
                      rsp_payload.remaining);
               error_count++;
            end
            if (rsp_payload.success !== want.success) begin
               $error("success: expected %0d, actual %0d", want.success,
                      rsp_payload.success);
               error_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_payload.last);
               error_count++;
            end
         end
      end
   end

   function automatic void model_payout(input req_type cmd);
      rsp_type           beat;
      logic [AMT_W-1:0]  owed;
      logic [AMT_W-1:0]  quot;
      logic [NOTE_W-1:0] take;
      beat = '0;
      if (cmd.func == FUNC_REFILL) begin
         beat.out_slot = cmd.slot;
         beat.last     = 1'b1;
         if (cmd.slot < SLOTS) begin
            shelf_stock[cmd.slot] = cmd.refill_count;
            beat.notes_used       = cmd.refill_count;
            beat.success          = 1'b1;
         end
         payout_queue.push_back(beat);
      end else begin
         owed = cmd.amount;
         for (int k = 0; k < SLOTS; k++) begin
            quot = (note_value[k] == '0) ? '1 : owed / note_value[k];
            take = (quot < shelf_stock[k]) ? quot[NOTE_W-1:0] : shelf_stock[k];
            owed = owed - take * note_value[k];
            shelf_stock[k]  = shelf_stock[k] - take;
            beat.out_slot   = k[SLOT_W-1:0];
            beat.notes_used = take;
            beat.remaining  = owed;
            beat.last       = (k == SLOTS - 1);
            beat.success    = beat.last && (owed == '0);
            payout_queue.push_back(beat);
         end
      end
   endfunction

   function automatic req_type dispense_cmd(input logic [AMT_W-1:0] amount);
      req_type cmd;
      cmd.func         = FUNC_DISPENSE;
      cmd.amount       = amount;
      cmd.slot         = SLOT_W'($urandom_range(0, SLOTS - 1));
      cmd.refill_count = NOTE_W'($urandom_range(0, 255));
      return cmd;
   endfunction

   function automatic req_type refill_cmd(input int slot, input int count);
      req_type cmd;
      cmd.func         = FUNC_REFILL;
      cmd.amount       = AMT_W'($urandom_range(0, 65535));
      cmd.slot         = slot[SLOT_W-1:0];
      cmd.refill_count = count[NOTE_W-1:0];
      return cmd;
   endfunction

   function automatic req_type random_command();
      req_type cmd;
      int      pick;
      int      total;
      if ($urandom_range(0, 99) < 30)
         return refill_cmd($urandom_range(0, SLOTS - 1), $urandom_range(0, 255));
      cmd  = dispense_cmd(AMT_W'($urandom_range(0, 65535)));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         total = 0;
         for (int k = 0; k < SLOTS; k++)
            total += $urandom_range(0, 4) * note_value[k];
         cmd.amount = total[AMT_W-1:0];
      end else if (pick < 65) begin
         cmd.amount = AMT_W'($urandom_range(0, 300));
      end else if (pick < 75) begin
         cmd.amount = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      return cmd;
   endfunction

   task automatic issue_command(input req_type cmd);
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (busy);
      model_payout(cmd);
   endtask

   // drop start, then hold for the rest of the gap
   task automatic hold_off(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 40));
      end
   endtask

   task automatic drain_payouts(input int tail);
      hold_off(1);
      while (payout_queue.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic put_note_value(input logic [IDX_W-1:0] index, input logic [AMT_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      note_value[index] = value;
   endtask

   task automatic load_note_values(input logic [AMT_W-1:0] v0, input logic [AMT_W-1:0] v1,
                                   input logic [AMT_W-1:0] v2, input logic [AMT_W-1:0] v3);
      drain_payouts(DRAIN_TAIL);
      put_note_value(REG_DENOM_0, v0);
      put_note_value(REG_DENOM_1, v1);
      put_note_value(REG_DENOM_2, v2);
      put_note_value(REG_DENOM_3, v3);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0)
            drain_payouts(0);
         issue_command(random_command());
         pace();
      end
   endtask

   task automatic test_empty_stock();
      issue_command(dispense_cmd('0));
      issue_command(dispense_cmd('1));
   endtask

   task automatic test_directed_payouts();
      for (int k = 0; k < SLOTS; k++)
         issue_command(refill_cmd(k, 255));
      // full stock cannot cover the largest amount; stock is spent anyway
      issue_command(dispense_cmd('1));
      issue_command(refill_cmd(0, 3));
      issue_command(refill_cmd(1, 1));
      issue_command(refill_cmd(2, 2));
      issue_command(refill_cmd(3, 0));
      issue_command(dispense_cmd(16'd390));
      issue_command(dispense_cmd('0));
      issue_command(dispense_cmd(16'd1));
      issue_command(refill_cmd(3, 255));
      issue_command(dispense_cmd(16'd255));
      issue_command(refill_cmd(0, 0));
      issue_command(dispense_cmd(16'd777));
   endtask

   task automatic test_random_traffic();
      run_random(40);
   endtask

   task automatic test_note_values();
      load_note_values('1, '1, '1, '1);
      issue_command(refill_cmd(0, 1));
      issue_command(dispense_cmd('1));
      run_random(24);
      load_note_values(16'd1, 16'd1, 16'd1, 16'd1);
      run_random(24);
      // zero note value: the divider saturates and the whole stock goes
      load_note_values('0, '1, '0, 16'd1);
      issue_command(refill_cmd(0, 7));
      issue_command(refill_cmd(2, 200));
      issue_command(dispense_cmd(16'd123));
      run_random(24);
      load_note_values(AMT_W'($urandom_range(1, 700)), AMT_W'($urandom_range(1, 700)),
                       AMT_W'($urandom_range(1, 700)), AMT_W'($urandom_range(1, 700)));
      run_random(24);
      load_note_values(DENOM_RESET[0], DENOM_RESET[1], DENOM_RESET[2], DENOM_RESET[3]);
      run_random(24);
   endtask

   initial begin
      for (int k = 0; k < NREGS; k++)
         note_value[k] = DENOM_RESET[k];
      for (int k = 0; k < SLOTS; k++)
         shelf_stock[k] = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_empty_stock();
      test_directed_payouts();
      test_random_traffic();
      test_note_values();
      drain_payouts(DRAIN_TAIL);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== greedy_note_dispenser_core.f =====
rtl/core/gnd_pkg.sv
rtl/core/gnd_cell.sv
rtl/core/greedy_note_dispenser_core.sv
tb/tb_top.sv
